/* src/ssida_pkg.sv */
package ssida_pkg;

    localparam int ID_W         = 10;
    localparam int CNT_W        = 11;
    localparam int DEF_CAPACITY = 1024;

    typedef enum logic [1:0] {
        OP_ADD     = 2'd0,
        OP_REQUEST = 2'd1,
        OP_REMOVE  = 2'd2,
        OP_QUERY   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_FULL = 2'd1,
        STAT_USED = 2'd2,
        STAT_FREE = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EVAL,
        ST_WR2,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic [CNT_W-1:0] used_count;
        status_t          status;
        logic             in_use;
        logic [ID_W-1:0]  result_id;
    } result_t;

endpackage

/* src/sparse_set_id_allocator.sv */
// Channel  | Ports           | Beat contents (lowest bit up)
// ---------+-----------------+---------------------------------------------------------
// input    | s_tdata/s_tuser | item_id[9:0] zero filled to 16 bits / operation[1:0]
// result   | m_tdata         | result_id[9:0], in_use, status[1:0], used_count[10:0]
//
// After reset the tables are swept to identity, one entry per cycle, over all
// CAPACITY entries; no input beat is taken until the sweep ends.
// A request or remove that moves entries writes each RAM twice (ST_EVAL, then ST_WR2)
// before ST_RESP loads the result register; every other operation goes from ST_EVAL to ST_RESP.
// One operation is in flight at a time: the next beat is taken only after ST_RESP has
// loaded the result, later while the previous result is held in the output register.
module sparse_set_id_allocator
#(
    parameter int CAPACITY = ssida_pkg::DEF_CAPACITY
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // item_id[9:0], zero fill
    input  logic [1:0]  s_tuser,   // operation[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // result_id, in_use, status, used_count
);

    import ssida_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int UW = $clog2(CAPACITY + 1);
    localparam int XW = (AW > ID_W) ? AW : ID_W;
    localparam int VW = (UW > CNT_W) ? UW : CNT_W;

    state_t            state_reg, state_next;
    logic [AW-1:0]     init_cnt_reg, init_cnt_next;
    logic [UW-1:0]     usage_reg, usage_next;
    op_t               op_reg, op_next;
    logic [ID_W-1:0]   id_reg, id_next;
    logic [AW-1:0]     b_reg, b_next;
    result_t           res_reg, res_next;
    logic              m_tvalid_reg, m_tvalid_next;
    result_t           m_tdata_reg, m_tdata_next;

    logic              dense_we, pos_we;
    logic [AW-1:0]     dense_waddr, dense_wdata, pos_waddr, pos_wdata;
    logic [AW-1:0]     dense_raddr, pos_raddr, dense_q, pos_q;

    logic [XW-1:0]     s_id_x, id_x, dense_x;
    logic [UW-1:0]     dense_sel;
    logic              id_ok, hit, full;
    logic [VW-1:0]     cnt_x;

    ssida_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_dense (
        .aclk  (aclk),
        .we    (dense_we),
        .waddr (dense_waddr),
        .wdata (dense_wdata),
        .raddr (dense_raddr),
        .rdata (dense_q)
    );

    ssida_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_pos (
        .aclk  (aclk),
        .we    (pos_we),
        .waddr (pos_waddr),
        .wdata (pos_wdata),
        .raddr (pos_raddr),
        .rdata (pos_q)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign s_id_x      = XW'(s_tdata[ID_W-1:0]);
    assign id_x        = XW'(id_reg);
    assign dense_x     = XW'(dense_q);
    assign dense_sel   = (op_t'(s_tuser) == OP_REMOVE) ? usage_reg - UW'(1) : usage_reg;
    assign dense_raddr = dense_sel[AW-1:0];
    assign pos_raddr   = s_id_x[AW-1:0];

    assign id_ok = (32'(id_reg) < 32'(CAPACITY));
    assign hit   = id_ok && (UW'(pos_q) < usage_reg);
    assign full  = (usage_reg == UW'(CAPACITY));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_INIT;
            init_cnt_reg <= '0;
            usage_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            init_cnt_reg <= init_cnt_next;
            usage_reg    <= usage_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        op_reg      <= op_next;
        id_reg      <= id_next;
        b_reg       <= b_next;
        res_reg     <= res_next;
        m_tdata_reg <= m_tdata_next;
    end

    always_comb begin
        state_next    = state_reg;
        init_cnt_next = init_cnt_reg;
        usage_next    = usage_reg;
        op_next       = op_reg;
        id_next       = id_reg;
        b_next        = b_reg;
        res_next      = res_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        dense_we      = 1'b0;
        pos_we        = 1'b0;
        dense_waddr   = init_cnt_reg;
        dense_wdata   = init_cnt_reg;
        pos_waddr     = init_cnt_reg;
        pos_wdata     = init_cnt_reg;
        cnt_x         = '0;

        unique case (state_reg)
            ST_INIT: begin
                dense_we      = 1'b1;
                pos_we        = 1'b1;
                init_cnt_next = init_cnt_reg + AW'(1);
                if (init_cnt_reg == AW'(CAPACITY - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    op_next    = op_t'(s_tuser);
                    id_next    = s_tdata[ID_W-1:0];
                    b_next     = dense_sel[AW-1:0];
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                res_next.result_id = id_reg;
                res_next.in_use    = 1'b0;
                res_next.status    = STAT_OK;
                state_next         = ST_RESP;
                unique case (op_reg)
                    OP_ADD: begin
                        if (full) begin
                            res_next.status    = STAT_FULL;
                            res_next.result_id = '0;
                        end else begin
                            res_next.result_id = dense_x[ID_W-1:0];
                            usage_next         = usage_reg + UW'(1);
                        end
                    end
                    OP_REQUEST: begin
                        if (!id_ok) begin
                            res_next.status = STAT_FULL;
                        end else if (hit) begin
                            res_next.status = STAT_USED;
                        end else begin
                            usage_next = usage_reg + UW'(1);
                            state_next = ST_WR2;
                        end
                    end
                    OP_REMOVE: begin
                        if (!hit) begin
                            res_next.status = STAT_FREE;
                        end else begin
                            usage_next = usage_reg - UW'(1);
                            state_next = ST_WR2;
                        end
                    end
                    OP_QUERY: begin
                        res_next.in_use = hit;
                    end
                    default: ;
                endcase
                // first half of the swap: dense[p] <= idb, pos[idb] <= p
                if (state_next == ST_WR2) begin
                    dense_we    = 1'b1;
                    pos_we      = 1'b1;
                    dense_waddr = pos_q;
                    dense_wdata = dense_q;
                    pos_waddr   = dense_q;
                    pos_wdata   = pos_q;
                end
                cnt_x               = VW'(usage_next);
                res_next.used_count = cnt_x[CNT_W-1:0];
            end
            ST_WR2: begin
                dense_we    = 1'b1;
                pos_we      = 1'b1;
                dense_waddr = b_reg;
                dense_wdata = id_x[AW-1:0];
                pos_waddr   = id_x[AW-1:0];
                pos_wdata   = b_reg;
                state_next  = ST_RESP;
            end
            ST_RESP: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = res_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_usage_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        usage_reg <= UW'(CAPACITY))
        else $error("usage above capacity");

    a_accept_eval: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_EVAL))
        else $error("accepted beat not evaluated");

    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> ($past(state_reg) == ST_RESP))
        else $error("result raised outside response step");

    a_usage_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_EVAL) |=> $stable(usage_reg))
        else $error("usage changed outside evaluation");

    a_swap_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WR2) |-> ($past(state_reg) == ST_EVAL && $past(dense_we)))
        else $error("second swap write without first");

endmodule

/* src/ssida_ram.sv */
module ssida_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
